>>> rtl/twhd_pkg.sv
// shared types, codes, constants and the rectangle hit test for the touch widget table
package twhd_pkg;

  // default table depth
  localparam int NUM_SLOTS_DEF = 16;

  // packed rectangle word: left, top, width, height from the low end
  localparam int COORD_W = 16;
  localparam int RECT_W  = 4 * COORD_W;

  // operation codes
  localparam logic [1:0] OP_REGISTER = 2'd0;
  localparam logic [1:0] OP_FREE     = 2'd1;
  localparam logic [1:0] OP_EVENT    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_HIT        = 3'd0;
  localparam logic [2:0] ST_NONE       = 3'd1;
  localparam logic [2:0] ST_IGNORED    = 3'd2;
  localparam logic [2:0] ST_REGISTERED = 3'd3;
  localparam logic [2:0] ST_FULL       = 3'd4;
  localparam logic [2:0] ST_FREED      = 3'd5;
  localparam logic [2:0] ST_OTHER      = 3'd6;

  // packet bytes
  localparam logic [7:0] KIND_BUTTON  = 8'h41;
  localparam logic [7:0] KIND_AREA    = 8'h48;
  localparam logic [7:0] AREA_LEN     = 8'd8;
  localparam logic [7:0] CODE_PRESS   = 8'd1;
  localparam logic [7:0] CODE_REPEAT  = 8'd2;
  localparam logic [7:0] BTN_SLOT_MSK = 8'h7f;
  localparam logic [7:0] BTN_PRESS    = 8'h80;

  // control sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  // inclusive hit test, edge sums at 17 bits so they never wrap
  function automatic logic point_in_rect(input logic [RECT_W-1:0] rect,
                                         input logic [COORD_W-1:0] x,
                                         input logic [COORD_W-1:0] y);
    logic [COORD_W:0] left;
    logic [COORD_W:0] top;
    logic [COORD_W:0] right;
    logic [COORD_W:0] bottom;
    left   = {1'b0, rect[COORD_W-1:0]};
    top    = {1'b0, rect[2*COORD_W-1:COORD_W]};
    right  = left + {1'b0, rect[3*COORD_W-1:2*COORD_W]};
    bottom = top + {1'b0, rect[4*COORD_W-1:3*COORD_W]};
    return ({1'b0, x} >= left) && ({1'b0, x} <= right) &&
           ({1'b0, y} >= top) && ({1'b0, y} <= bottom);
  endfunction

endpackage

>>> rtl/touch_widget_hit_dispatch.sv
// touch widget slot table: register, free and touch event dispatch
// sequencing: free, button and other-kind words form their result on acceptance;
// register words and area words of length AREA_LEN that are not repeats walk the table
// from the top slot down, one slot per cycle through the rectangle memory, to the first hit
// throughput: one word at a time; a new word is taken only once the last result is loaded
// reset: synchronous, clears all occupied marks; the rectangle memory is not swept
module touch_widget_hit_dispatch
  import twhd_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          op,
  input  logic [COORD_W-1:0]  pos_x,
  input  logic [COORD_W-1:0]  pos_y,
  input  logic [COORD_W-1:0]  rect_width,
  input  logic [COORD_W-1:0]  rect_height,
  input  logic [3:0]          target_slot,
  input  logic [7:0]          pkt_len,
  input  logic [7:0]          pkt_kind,
  input  logic [7:0]          pkt_code,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          status,
  output logic [3:0]          slot_index,
  output logic                pressed,
  output logic                activity
);

  localparam int         IW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [7:0] NS8 = 8'(NUM_SLOTS);
  localparam logic [IW-1:0] TOP_IDX = IW'(NUM_SLOTS - 1);

  state_t state, state_next;

  // held operands of the word being worked on
  logic [COORD_W-1:0] px_q, py_q, w_q, h_q;
  logic [7:0]         code_q;
  logic               scan_reg;

  // occupied marks
  logic [NUM_SLOTS-1:0] used;

  // scan pipeline: issue stage and compare stage
  logic [IW-1:0] iss_idx, cmp_idx;
  logic          iss_act, cmp_vld;

  // pending result
  logic [2:0] res_status;
  logic [3:0] res_slot;
  logic       res_pressed, res_act;

  logic              acc, rd_en, out_load, mem_we;
  logic [RECT_W-1:0] rd_data;
  logic              cmp_used, in_rect, cmp_hit, scan_end;
  logic [7:0]        btn_b, tslot8, cmp8;
  logic              btn_ok, tslot_ok, start_scan;

  // decode of the incoming word
  always_comb begin
    acc        = in_valid && in_ready;
    btn_b      = {1'b0, pkt_code[6:0] & BTN_SLOT_MSK[6:0]} - 8'd1;
    btn_ok     = (btn_b < NS8) ? used[btn_b[IW-1:0]] : 1'b0;
    tslot8     = 8'(target_slot);
    tslot_ok   = tslot8 < NS8;
    start_scan = (op == OP_REGISTER) ||
                 ((op == OP_EVENT) && (pkt_kind == KIND_AREA) &&
                  (pkt_len == AREA_LEN) && (pkt_code != CODE_REPEAT));
  end

  // compare stage of the scan
  always_comb begin
    cmp_used = used[cmp_idx];
    in_rect  = point_in_rect(rd_data, px_q, py_q);
    cmp_hit  = cmp_vld && (scan_reg ? !cmp_used : (cmp_used && in_rect));
    scan_end = cmp_hit || (cmp_vld && !iss_act);
    cmp8     = 8'(cmp_idx);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          state_next = start_scan ? S_SCAN : S_DONE;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    out_load = 1'b0;
    mem_we   = 1'b0;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_SCAN: begin
        rd_en  = iss_act;
        mem_we = cmp_hit && scan_reg;
      end
      S_DONE: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (acc) begin
      px_q     <= pos_x;
      py_q     <= pos_y;
      w_q      <= rect_width;
      h_q      <= rect_height;
      code_q   <= pkt_code;
      scan_reg <= (op == OP_REGISTER);
    end
  end

  // scan index pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_act <= 1'b0;
      cmp_vld <= 1'b0;
    end else if (acc) begin
      iss_act <= start_scan;
      cmp_vld <= 1'b0;
    end else if (state == S_SCAN) begin
      if (scan_end) begin
        iss_act <= 1'b0;
        cmp_vld <= 1'b0;
      end else begin
        cmp_vld <= iss_act;
        if (iss_act && (iss_idx == '0)) begin
          iss_act <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      iss_idx <= TOP_IDX;
    end else if (rd_en) begin
      cmp_idx <= iss_idx;
      iss_idx <= iss_idx - IW'(1);
    end
  end

  // occupied marks
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (acc && (op == OP_FREE) && tslot_ok) begin
      used[tslot8[IW-1:0]] <= 1'b0;
    end else if (mem_we) begin
      used[cmp_idx] <= 1'b1;
    end
  end

  // result forming
  always_ff @(posedge clk) begin
    if (acc) begin
      res_status  <= ST_IGNORED;
      res_slot    <= 4'd0;
      res_pressed <= 1'b0;
      res_act     <= 1'b0;
      case (op)
        OP_REGISTER: res_status <= ST_FULL;
        OP_FREE: begin
          res_slot <= target_slot;
          if (tslot_ok) begin
            res_status <= ST_FREED;
          end
        end
        OP_EVENT: begin
          res_act <= 1'b1;
          if (pkt_kind == KIND_BUTTON) begin
            res_status <= ST_NONE;
            if (btn_ok) begin
              res_status  <= ST_HIT;
              res_slot    <= btn_b[3:0];
              res_pressed <= (pkt_code & BTN_PRESS) != 8'd0;
            end
          end else if (pkt_kind == KIND_AREA) begin
            if (start_scan) begin
              res_status <= ST_NONE;
            end
          end else begin
            res_status <= ST_OTHER;
          end
        end
        default: ;
      endcase
    end else if ((state == S_SCAN) && cmp_hit) begin
      res_slot <= cmp8[3:0];
      if (scan_reg) begin
        res_status <= ST_REGISTERED;
      end else begin
        res_status  <= ST_HIT;
        res_pressed <= (code_q == CODE_PRESS);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status     <= res_status;
      slot_index <= res_slot;
      pressed    <= res_pressed;
      activity   <= res_act;
    end
  end

  twhd_rect_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_rect_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cmp_idx),
    .wdata ({h_q, w_q, py_q, px_q}),
    .re    (rd_en),
    .raddr (iss_idx),
    .rdata (rd_data)
  );

endmodule

>>> rtl/twhd_rect_mem.sv
// rectangle store: one write port, one read port with registered read data
module twhd_rect_mem
  import twhd_pkg::*;
#(
  parameter int DEPTH = NUM_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [RECT_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [RECT_W-1:0] rdata
);

  logic [RECT_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
